// ----- rtl/core/fsmf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsmf_pkg
// shared types and constants of the fixed-slot message queue
// ----------------------------------------------------------------------------
package fsmf_pkg;

  // operation codes of an input word
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_FLUSH = 2'd2
  } op_e;

  // status codes of a result word
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DROP  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // what the back end has to do with a queued command
  typedef enum logic {
    CMD_SINGLE = 1'b0,
    CMD_POP    = 1'b1
  } cmd_kind_e;

  // back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_LEN  = 2'd1,
    B_RUN  = 2'd2
  } back_state_e;

  // command passed from front to back
  typedef struct packed {
    cmd_kind_e kind;
    status_e   status;
    logic      is_empty;
    logic      is_full;
  } cmd_t;

  // fixed field widths
  localparam int SIU_W  = 4;  // slots in use register
  localparam int SLEN_W = 5;  // slot length register, message length
  localparam int CNT_W  = 4;  // stored message count
  localparam int BYTE_W = 8;

  // depth of the command queue between front and back
  localparam int QDEPTH = 2;

endpackage : fsmf_pkg
`default_nettype wire

// ----- rtl/core/fixed_slot_message_fifo_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_slot_message_fifo_core
// ring of fixed-size slots holding variable-length byte messages
// ----------------------------------------------------------------------------
//  channel  direction  handshake                     payload
//  in       sink       in_valid_i / in_ready_o       operation, data_byte, last_byte
//  out      source     out_valid_o / out_ready_i     out_byte, out_last, message_length,
//                                                    status, is_empty, is_full
//  cfg      apb slave  psel, penable, pwrite, pready paddr, pwdata, prdata
//
//  push, flush and unused codes give one result word each; the front takes the
//  next word while the result waits in the output register.
//  a pop of n bytes shows its first word after the queue, the registered length
//  read and the registered byte read, then one byte per cycle while the output
//  is not stalled; input words are held off until the last byte word is loaded.
//  reset clears pointers and counts; the stores need no clearing pass.
//  a stalled output holds its word and stalls the read-out in place.
// ----------------------------------------------------------------------------
module fixed_slot_message_fifo_core #(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input words
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [1:0]                          operation_i,
  input  wire logic [fsmf_pkg::BYTE_W-1:0]         data_byte_i,
  input  wire logic                                last_byte_i,
  // result words
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [fsmf_pkg::BYTE_W-1:0]              out_byte_o,
  output logic                                     out_last_o,
  output logic [fsmf_pkg::SLEN_W-1:0]              message_length_o,
  output logic [1:0]                               status_o,
  output logic                                     is_empty_o,
  output logic                                     is_full_o,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [2:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);
  import fsmf_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int AW = $clog2(SLOTS * SLOT_BYTES);
  localparam int SiuMax = (SLOTS > 15) ? 15 : SLOTS;
  localparam int SiuRst = (SLOTS > 8) ? 8 : SLOTS;
  localparam int SlenMax = (SLOT_BYTES > 31) ? 31 : SLOT_BYTES;
  localparam int SlenRst = (SLOT_BYTES > 16) ? 16 : SLOT_BYTES;
  localparam logic REG_SLOTS_IN_USE = 1'b0;
  localparam logic REG_SLOT_LENGTH  = 1'b1;

  logic [SIU_W-1:0]  siu_q;
  logic [SLEN_W-1:0] slen_q;
  logic [SIU_W-1:0]  siu_wr;
  logic [SLEN_W-1:0] slen_wr;
  logic              cfg_wr;

  cmd_t              f_cmd, b_cmd;
  logic [SW-1:0]     f_slot, b_slot;
  logic              q_push, q_full, q_valid, q_pop, pop_done;
  logic              bwr_en, lwr_en;
  logic [AW-1:0]     bwr_addr, brd_addr;
  logic [BYTE_W-1:0] bwr_data, brd_data;
  logic [SW-1:0]     lwr_addr, lrd_addr;
  logic [SLEN_W-1:0] lwr_data, lrd_data;

  // configuration registers, writes saturate into the legal range
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign siu_wr = (pwdata[SIU_W-1:0] == '0) ? SIU_W'(1) :
                  (pwdata[SIU_W-1:0] > SIU_W'(SiuMax)) ? SIU_W'(SiuMax) :
                  pwdata[SIU_W-1:0];
  assign slen_wr = (pwdata[SLEN_W-1:0] == '0) ? SLEN_W'(1) :
                   (pwdata[SLEN_W-1:0] > SLEN_W'(SlenMax)) ? SLEN_W'(SlenMax) :
                   pwdata[SLEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      siu_q  <= SIU_W'(SiuRst);
      slen_q <= SLEN_W'(SlenRst);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SLOTS_IN_USE) begin
        siu_q <= siu_wr;
      end else begin
        slen_q <= slen_wr;
      end
    end
  end

  // register read-back
  always_comb begin
    unique case (paddr[2])
      REG_SLOTS_IN_USE: prdata = 32'(siu_q);
      REG_SLOT_LENGTH:  prdata = 32'(slen_q);
      default:          prdata = '0;
    endcase
  end

  // front end
  fsmf_front #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .slots_in_use_i (siu_q),
    .slot_length_i  (slen_q),
    .q_push_o       (q_push),
    .q_cmd_o        (f_cmd),
    .q_slot_o       (f_slot),
    .q_full_i       (q_full),
    .pop_done_i     (pop_done),
    .bwr_en_o       (bwr_en),
    .bwr_addr_o     (bwr_addr),
    .bwr_data_o     (bwr_data),
    .lwr_en_o       (lwr_en),
    .lwr_addr_o     (lwr_addr),
    .lwr_data_o     (lwr_data)
  );

  // command queue
  fsmf_cmdq #(
    .SLOT_W (SW)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (f_cmd),
    .slot_i  (f_slot),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (b_cmd),
    .slot_o  (b_slot),
    .pop_i   (q_pop)
  );

  // message bytes
  fsmf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SLOTS * SLOT_BYTES)
  ) u_byte_ram (
    .clk_i     (clk_i),
    .wr_en_i   (bwr_en),
    .wr_addr_i (bwr_addr),
    .wr_data_i (bwr_data),
    .rd_addr_i (brd_addr),
    .rd_data_o (brd_data)
  );

  // per-slot message lengths
  fsmf_ram #(
    .WIDTH (SLEN_W),
    .DEPTH (SLOTS)
  ) u_len_ram (
    .clk_i     (clk_i),
    .wr_en_i   (lwr_en),
    .wr_addr_i (lwr_addr),
    .wr_data_i (lwr_data),
    .rd_addr_i (lrd_addr),
    .rd_data_o (lrd_data)
  );

  // back end
  fsmf_back #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_cmd_i          (b_cmd),
    .q_slot_i         (b_slot),
    .q_pop_o          (q_pop),
    .pop_done_o       (pop_done),
    .lrd_addr_o       (lrd_addr),
    .lrd_data_i       (lrd_data),
    .brd_addr_o       (brd_addr),
    .brd_data_i       (brd_data),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .out_last_o       (out_last_o),
    .message_length_o (message_length_o),
    .status_o         (status_o),
    .is_empty_o       (is_empty_o),
    .is_full_o        (is_full_o)
  );

endmodule : fixed_slot_message_fifo_core
`default_nettype wire

// ----- rtl/core/fsmf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsmf_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module fsmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule : fsmf_ram
`default_nettype wire

// ----- rtl/core/fsmf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsmf_front
// accepts input words, keeps ring pointers and counts, writes the stores and
// queues one command per word for the back end
// ----------------------------------------------------------------------------
module fsmf_front #(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // input words
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [1:0]                            operation_i,
  input  wire logic [fsmf_pkg::BYTE_W-1:0]           data_byte_i,
  input  wire logic                                  last_byte_i,
  // configuration
  input  wire logic [fsmf_pkg::SIU_W-1:0]            slots_in_use_i,
  input  wire logic [fsmf_pkg::SLEN_W-1:0]           slot_length_i,
  // command queue
  output logic                                       q_push_o,
  output fsmf_pkg::cmd_t                             q_cmd_o,
  output logic [$clog2(SLOTS)-1:0]                   q_slot_o,
  input  wire logic                                  q_full_i,
  input  wire logic                                  pop_done_i,
  // byte store write
  output logic                                       bwr_en_o,
  output logic [$clog2(SLOTS*SLOT_BYTES)-1:0]        bwr_addr_o,
  output logic [fsmf_pkg::BYTE_W-1:0]                bwr_data_o,
  // length store write
  output logic                                       lwr_en_o,
  output logic [$clog2(SLOTS)-1:0]                   lwr_addr_o,
  output logic [fsmf_pkg::SLEN_W-1:0]                lwr_data_o
);
  import fsmf_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int AW = $clog2(SLOTS * SLOT_BYTES);
  localparam int CW = (SW + 1 > SIU_W) ? SW + 1 : SIU_W;
  localparam int SiuMax = (SLOTS > 15) ? 15 : SLOTS;

  logic [SW-1:0]     wr_slot_q, wr_slot_d;
  logic [SW-1:0]     rd_slot_q, rd_slot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SLEN_W-1:0] fill_q, fill_d;
  logic              drop_q, drop_d;
  logic              pend_q, pend_d;
  logic              acc;
  logic              full_now;
  status_e           st;
  cmd_kind_e         kind;

  // advance a slot index, wrapping at the ring size
  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s,
                                               input logic [SIU_W-1:0] siu);
    logic [CW-1:0] inc;
    inc = CW'(s) + CW'(1);
    return (inc >= CW'(siu)) ? '0 : inc[SW-1:0];
  endfunction

  // no new word while a popped message is still being read out
  assign in_ready_o = !q_full_i && !pend_q;
  assign acc        = in_valid_i && in_ready_o;
  assign full_now   = cnt_q >= slots_in_use_i;

  // classify the word and work out the next state
  always_comb begin
    wr_slot_d  = wr_slot_q;
    rd_slot_d  = rd_slot_q;
    cnt_d      = cnt_q;
    fill_d     = fill_q;
    drop_d     = drop_q;
    pend_d     = pend_q;
    st         = ST_OK;
    kind       = CMD_SINGLE;
    bwr_en_o   = 1'b0;
    lwr_en_o   = 1'b0;
    bwr_addr_o = AW'(wr_slot_q * SLOT_BYTES + fill_q);
    bwr_data_o = data_byte_i;
    lwr_addr_o = wr_slot_q;
    lwr_data_o = fill_q + SLEN_W'(1);
    if (pop_done_i) begin
      pend_d = 1'b0;
    end
    if (acc) begin
      case (operation_i)
        OP_PUSH: begin
          if (full_now) begin
            st = ST_FULL;
          end else if (drop_q || fill_q >= slot_length_i) begin
            st     = ST_DROP;
            drop_d = !last_byte_i;
            fill_d = '0;
          end else begin
            bwr_en_o = 1'b1;
            fill_d   = fill_q + SLEN_W'(1);
            if (last_byte_i) begin
              lwr_en_o  = 1'b1;
              wr_slot_d = next_slot(wr_slot_q, slots_in_use_i);
              cnt_d     = cnt_q + CNT_W'(1);
              fill_d    = '0;
            end
          end
        end
        OP_POP: begin
          if (cnt_q == '0) begin
            st = ST_EMPTY;
          end else begin
            kind      = CMD_POP;
            rd_slot_d = next_slot(rd_slot_q, slots_in_use_i);
            cnt_d     = cnt_q - CNT_W'(1);
            pend_d    = 1'b1;
          end
        end
        OP_FLUSH: begin
          wr_slot_d = rd_slot_q;
          cnt_d     = '0;
          fill_d    = '0;
          drop_d    = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // command towards the back end, flags as they stand after this word
  assign q_push_o         = acc;
  assign q_slot_o         = rd_slot_q;
  assign q_cmd_o.kind     = kind;
  assign q_cmd_o.status   = st;
  assign q_cmd_o.is_empty = (cnt_d == '0);
  assign q_cmd_o.is_full  = (cnt_d >= slots_in_use_i);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot_q <= '0;
      rd_slot_q <= '0;
      cnt_q     <= '0;
      fill_q    <= '0;
      drop_q    <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      wr_slot_q <= wr_slot_d;
      rd_slot_q <= rd_slot_d;
      cnt_q     <= cnt_d;
      fill_q    <= fill_d;
      drop_q    <= drop_d;
      pend_q    <= pend_d;
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(SiuMax))
    else $error("message count beyond ring size");

  a_pop_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && operation_i == OP_POP && cnt_q != '0) |=> pend_q)
    else $error("pop issued without blocking further words");

endmodule : fsmf_front
`default_nettype wire

// ----- rtl/core/fsmf_cmdq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsmf_cmdq
// short command queue between front and back end
// ----------------------------------------------------------------------------
module fsmf_cmdq #(
  parameter int SLOT_W = 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire fsmf_pkg::cmd_t    cmd_i,
  input  wire logic [SLOT_W-1:0] slot_i,
  output logic                   full_o,
  output logic                   valid_o,
  output fsmf_pkg::cmd_t         cmd_o,
  output logic [SLOT_W-1:0]      slot_o,
  input  wire logic              pop_i
);
  import fsmf_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  cmd_t              cmd_q  [QDEPTH];
  logic [SLOT_W-1:0] slot_q [QDEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]     cnt_q;

  assign full_o  = (cnt_q == NW'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = cmd_q[rd_ptr_q];
  assign slot_o  = slot_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cmd_q[wr_ptr_q]  <= cmd_i;
      slot_q[wr_ptr_q] <= slot_i;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

endmodule : fsmf_cmdq
`default_nettype wire

// ----- rtl/core/fsmf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsmf_back
// takes queued commands, reads popped messages out of the stores and drives
// the result word register
// ----------------------------------------------------------------------------
module fsmf_back #(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // command queue
  input  wire logic                                  q_valid_i,
  input  wire fsmf_pkg::cmd_t                        q_cmd_i,
  input  wire logic [$clog2(SLOTS)-1:0]              q_slot_i,
  output logic                                       q_pop_o,
  output logic                                       pop_done_o,
  // store reads
  output logic [$clog2(SLOTS)-1:0]                   lrd_addr_o,
  input  wire logic [fsmf_pkg::SLEN_W-1:0]           lrd_data_i,
  output logic [$clog2(SLOTS*SLOT_BYTES)-1:0]        brd_addr_o,
  input  wire logic [fsmf_pkg::BYTE_W-1:0]           brd_data_i,
  // result words
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [fsmf_pkg::BYTE_W-1:0]                out_byte_o,
  output logic                                       out_last_o,
  output logic [fsmf_pkg::SLEN_W-1:0]                message_length_o,
  output logic [1:0]                                 status_o,
  output logic                                       is_empty_o,
  output logic                                       is_full_o
);
  import fsmf_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int AW = $clog2(SLOTS * SLOT_BYTES);
  localparam int LenCap = (SLOT_BYTES > 31) ? 31 : SLOT_BYTES;

  back_state_e       state_q, state_d;
  logic [SW-1:0]     slot_q, slot_d;
  logic [SLEN_W-1:0] len_q, len_d;
  logic [SLEN_W-1:0] idx_q, idx_d;
  logic              empty_q, empty_d;
  logic              full_q, full_d;
  logic [SLEN_W-1:0] off;
  logic              out_free;
  logic              run_last;
  logic              load;
  logic [BYTE_W-1:0] ld_byte;
  logic              ld_last;
  logic [SLEN_W-1:0] ld_len;
  status_e           ld_status;
  logic              ld_empty, ld_full;
  logic              out_valid_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign run_last = (len_q == '0) || (idx_q + SLEN_W'(1) == len_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (q_valid_i && q_cmd_i.kind == CMD_POP) begin
          state_d = B_LEN;
        end
      end
      B_LEN: begin
        state_d = B_RUN;
      end
      B_RUN: begin
        if (out_free && run_last) begin
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop_o    = 1'b0;
    pop_done_o = 1'b0;
    load       = 1'b0;
    ld_byte    = '0;
    ld_last    = 1'b1;
    ld_len     = '0;
    ld_status  = ST_OK;
    ld_empty   = empty_q;
    ld_full    = full_q;
    slot_d     = slot_q;
    len_d      = len_q;
    idx_d      = idx_q;
    empty_d    = empty_q;
    full_d     = full_q;
    off        = idx_q;
    lrd_addr_o = slot_q;
    unique case (state_q)
      B_IDLE: begin
        lrd_addr_o = q_slot_i;
        if (q_valid_i) begin
          if (q_cmd_i.kind == CMD_POP) begin
            q_pop_o = 1'b1;
            slot_d  = q_slot_i;
            empty_d = q_cmd_i.is_empty;
            full_d  = q_cmd_i.is_full;
          end else if (out_free) begin
            q_pop_o   = 1'b1;
            load      = 1'b1;
            ld_status = q_cmd_i.status;
            ld_empty  = q_cmd_i.is_empty;
            ld_full   = q_cmd_i.is_full;
          end
        end
      end
      B_LEN: begin
        // length arrives, clamp it and fetch the first byte
        len_d = (lrd_data_i > SLEN_W'(LenCap)) ? SLEN_W'(LenCap) : lrd_data_i;
        idx_d = '0;
        off   = '0;
      end
      B_RUN: begin
        if (out_free) begin
          load    = 1'b1;
          ld_byte = (len_q == '0) ? '0 : brd_data_i;
          ld_last = run_last;
          ld_len  = len_q;
          if (run_last) begin
            pop_done_o = 1'b1;
          end else begin
            idx_d = idx_q + SLEN_W'(1);
            off   = idx_q + SLEN_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    brd_addr_o = AW'(slot_q * SLOT_BYTES + off);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // run context and result word payload
  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    len_q   <= len_d;
    idx_q   <= idx_d;
    empty_q <= empty_d;
    full_q  <= full_d;
    if (load) begin
      out_byte_o       <= ld_byte;
      out_last_o       <= ld_last;
      message_length_o <= ld_len;
      status_o         <= ld_status;
      is_empty_o       <= ld_empty;
      is_full_o        <= ld_full;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_len_to_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_LEN |=> state_q == B_RUN)
    else $error("length fetch not followed by read-out");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_RUN |-> (idx_q < len_q || len_q == '0))
    else $error("byte index past message length");

endmodule : fsmf_back
`default_nettype wire
